// ===== rtl/pde_pkg.sv =====
// ----------------------------------------------------------------------------
// Predictive delta encoder package
// Shared constants, the front-to-back command record and its slot mask.
// ----------------------------------------------------------------------------
`default_nettype none

package pde_pkg;

  // Series length register.
  localparam logic [14:0] TimeStepsReset = 15'd3;
  localparam logic [14:0] TimeStepsMin   = 15'd3;

  // Stream codes.
  localparam logic [7:0] MarkNew    = 8'h80;
  localparam logic [7:0] MarkEscape = 8'h7F;

  // Residuals strictly inside +/- this limit go out as one byte.
  localparam logic signed [15:0] NearLimit = 16'sd127;

  // Default depth of the command queue between front and back.
  localparam int CmdQueueDepth = 4;

  // Number of byte slots a command can fill.
  localparam int NumSlots = 7;

  // Byte slots in stream order.
  typedef enum logic [2:0] {
    SlotOpen    = 3'd0,
    SlotWordLo  = 3'd1,
    SlotWordHi  = 3'd2,
    SlotCode    = 3'd3,
    SlotResidLo = 3'd4,
    SlotResidHi = 3'd5,
    SlotClose   = 3'd6
  } slot_e;

  typedef logic [NumSlots-1:0] slot_mask_t;

  // One accepted sample, classified into the bytes it produces.
  typedef struct packed {
    logic        mark_open;   // File opening marker.
    logic        word_en;     // First value or arrival index follows.
    logic [15:0] word;
    logic        code_en;     // A residual is coded.
    logic        esc;         // Residual needs the escape form.
    logic [15:0] resid;
    logic        mark_close;  // Series closing marker.
  } cmd_t;

  // Which byte slots a command fills.
  function automatic slot_mask_t slot_mask(input cmd_t cmd);
    slot_mask_t m;
    m              = '0;
    m[SlotOpen]    = cmd.mark_open;
    m[SlotWordLo]  = cmd.word_en;
    m[SlotWordHi]  = cmd.word_en;
    m[SlotCode]    = cmd.code_en;
    m[SlotResidLo] = cmd.code_en & cmd.esc;
    m[SlotResidHi] = cmd.code_en & cmd.esc;
    m[SlotClose]   = cmd.mark_close;
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pde_in_if.sv =====
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one sample and its new-file flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface pde_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               new_file;

  modport source (output valid, sample, new_file, input ready);
  modport sink   (input valid, sample, new_file, output ready);
endinterface

`default_nettype wire

// ===== rtl/pde_out_if.sv =====
// ----------------------------------------------------------------------------
// Byte channel
// Valid/ready channel carrying one stream byte and its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface pde_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/pde_front.sv =====
// ----------------------------------------------------------------------------
// Encoder front end
// Accepts samples, tracks the series state and classifies each sample into
// a command for the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module pde_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [14:0]  cfg_wdata_i,
  pde_in_if.sink            in_i,
  input  wire logic         q_ready_i,
  output logic              push_valid_o,
  output pde_pkg::cmd_t     push_cmd_o
);
  import pde_pkg::*;

  logic [14:0] time_steps_q;
  logic [14:0] sample_index_q, sample_index_d;
  logic        in_run_q, in_run_d;
  logic [15:0] first_value_q, first_value_d;
  logic [15:0] prev_one_q, prev_one_d;
  logic [15:0] prev_two_q, prev_two_d;

  logic               accept;
  logic [14:0]        ts_eff;
  logic [14:0]        last_idx;
  logic [14:0]        idx_cur;
  logic [15:0]        s_u;
  logic [15:0]        pred;
  logic [15:0]        resid_u;
  logic signed [15:0] resid_s;
  logic               at_end;
  logic               code_it;
  cmd_t               cmd;

  // A sample transfers whenever the command queue has room.
  assign in_i.ready = q_ready_i;
  assign accept     = in_i.valid & q_ready_i;

  // Effective series length and second-order residual.
  always_comb begin
    ts_eff   = (time_steps_q < TimeStepsMin) ? TimeStepsMin : time_steps_q;
    last_idx = ts_eff - 15'd1;
    idx_cur  = in_i.new_file ? 15'd0 : sample_index_q;
    s_u      = $unsigned(in_i.sample);
    pred     = {prev_one_q[14:0], 1'b0} - prev_two_q;
    resid_u  = s_u - pred;
    resid_s  = $signed(resid_u);
  end

  // Classification and next series state.
  always_comb begin
    sample_index_d = sample_index_q;
    in_run_d       = in_run_q;
    first_value_d  = first_value_q;
    prev_one_d     = prev_one_q;
    prev_two_d     = prev_two_q;
    at_end         = 1'b0;
    code_it        = 1'b0;

    cmd            = '0;
    cmd.mark_open  = in_i.new_file;
    cmd.resid      = resid_u;
    cmd.esc        = !((resid_s > -NearLimit) && (resid_s < NearLimit));

    if (idx_cur == 15'd0) begin
      // First sample of a series: emit it and seed the predictor.
      cmd.word_en    = 1'b1;
      cmd.word       = s_u;
      first_value_d  = s_u;
      prev_one_d     = s_u;
      prev_two_d     = s_u;
      in_run_d       = 1'b1;
      sample_index_d = 15'd1;
    end else begin
      at_end  = (idx_cur >= last_idx);
      code_it = !in_run_q || (s_u != first_value_q) || at_end;
      // The arrival ends the leading run and reports its index.
      cmd.word_en = in_run_q & code_it;
      cmd.word    = {1'b0, idx_cur};
      cmd.code_en = code_it;
      if (code_it) begin
        prev_two_d = prev_one_q;
        prev_one_d = s_u;
        in_run_d   = 1'b0;
      end
      if (at_end) begin
        cmd.mark_close = 1'b1;
        sample_index_d = 15'd0;
        in_run_d       = 1'b1;
      end else begin
        sample_index_d = idx_cur + 15'd1;
      end
    end
  end

  // Suppressed samples produce no command.
  assign push_valid_o = accept & (|slot_mask(cmd));
  assign push_cmd_o   = cmd;

  // Series state and configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_steps_q   <= TimeStepsReset;
      sample_index_q <= '0;
      in_run_q       <= 1'b1;
      first_value_q  <= '0;
      prev_one_q     <= '0;
      prev_two_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        time_steps_q <= cfg_wdata_i;
      end
      if (accept) begin
        sample_index_q <= sample_index_d;
        in_run_q       <= in_run_d;
        first_value_q  <= first_value_d;
        prev_one_q     <= prev_one_d;
        prev_two_q     <= prev_two_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pde_queue.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Small FIFO of commands that decouples the front end from the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module pde_queue #(
  parameter int Depth = pde_pkg::CmdQueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire pde_pkg::cmd_t  push_cmd_i,
  output logic                ready_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output pde_pkg::cmd_t       pop_cmd_o
);
  import pde_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign ready_o   = (count_q != FullCnt);
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];
  assign do_push   = push_i & ready_o;
  assign do_pop    = pop_i & valid_o;

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pde_back.sv =====
// ----------------------------------------------------------------------------
// Byte serializer
// Takes commands from the queue and emits their bytes one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module pde_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  wire pde_pkg::cmd_t  q_cmd_i,
  output logic                pop_o,
  pde_out_if.source           out_o
);
  import pde_pkg::*;

  slot_mask_t mask_q, mask_d;
  cmd_t       cmd_q;
  slot_mask_t cur;
  slot_mask_t rest;
  logic       fire;
  logic       load;

  // The lowest pending slot is the byte on the output.
  assign cur  = mask_q & (~mask_q + slot_mask_t'(1));
  assign rest = mask_q & ~cur;
  assign fire = out_o.valid & out_o.ready;

  assign out_o.valid = |mask_q;
  assign out_o.last  = (rest == '0);

  // Byte selection.
  always_comb begin
    priority if (mask_q[SlotOpen]) begin
      out_o.out_byte = MarkNew;
    end else if (mask_q[SlotWordLo]) begin
      out_o.out_byte = cmd_q.word[7:0];
    end else if (mask_q[SlotWordHi]) begin
      out_o.out_byte = cmd_q.word[15:8];
    end else if (mask_q[SlotCode]) begin
      out_o.out_byte = cmd_q.esc ? MarkEscape : cmd_q.resid[7:0];
    end else if (mask_q[SlotResidLo]) begin
      out_o.out_byte = cmd_q.resid[7:0];
    end else if (mask_q[SlotResidHi]) begin
      out_o.out_byte = cmd_q.resid[15:8];
    end else begin
      out_o.out_byte = MarkNew;
    end
  end

  // Load the next command when idle or on the final byte's transfer.
  always_comb begin
    load   = (mask_q == '0) || (fire && (rest == '0));
    pop_o  = load & q_valid_i;
    mask_d = mask_q;
    if (load) begin
      mask_d = q_valid_i ? slot_mask(q_cmd_i) : '0;
    end else if (fire) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= q_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/predictive_delta_series_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// Predictive delta series encoder
// Second-order predictive delta coder for series of signed 16-bit samples.
// ----------------------------------------------------------------------------
// The block takes one sample whenever its command queue has room, and emits
// the stream one byte per cycle while the output is ready. A typical sample
// costs one output byte, an escaped residual three, and the first sample of a
// series or the arrival up to six; throughput is one sample per output byte it
// produces, set by the byte serializer, while the command queue (QueueDepth
// entries) absorbs longer bursts. Write time_steps via cfg_we_i/cfg_wdata_i
// only while the block is idle; the block does not enforce it.
`default_nettype none

module predictive_delta_series_encoder_unit #(
  parameter int QueueDepth = pde_pkg::CmdQueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [14:0] cfg_wdata_i,
  pde_in_if.sink           in_i,
  pde_out_if.source        out_o
);
  import pde_pkg::*;

  logic push_valid;
  cmd_t push_cmd;
  logic q_ready;
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  pde_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_i         (in_i),
    .q_ready_i    (q_ready),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd)
  );

  pde_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_valid),
    .push_cmd_i (push_cmd),
    .ready_o    (q_ready),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (q_cmd)
  );

  pde_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .pop_o     (pop),
    .out_o     (out_o)
  );

  // The front end never pushes a command the queue cannot hold.
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> q_ready)
    else $error("command pushed into a full queue");

  // The serializer only takes commands that are present.
  a_pop_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("command popped from an empty queue");

  // A new-file sample always leads with the opening marker once it reaches
  // an empty pipeline: it is registered in the queue, then loaded into the serializer.
  a_open_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.new_file && !q_valid && !out_o.valid)
    |-> ##2 (out_o.valid && out_o.out_byte == MarkNew))
    else $error("opening marker missing");

endmodule

`default_nettype wire

// ===== tb/sv/predictive_delta_series_encoder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Predictive delta series encoder testbench
// Drives sample series with random gaps and back-pressure, predicts the byte
// stream in a scoreboard and checks every output transfer against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module predictive_delta_series_encoder_unit_tb;

  import pde_pkg::*;

  // Cycles to let the block settle before a length write, and the
  // watchdog limit on cycles without any transfer.
  localparam int SettleCycles = 20;
  localparam int StallLimit   = 4000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  // Scoreboard: tracks the coder state and holds the bytes still owed.
  class delta_stream_board;
    stream_byte_t owed_bytes[$];
    logic [14:0]  steps;
    logic [14:0]  position;
    logic         leading;
    logic [15:0]  first_val;
    logic [15:0]  hist_one;
    logic [15:0]  hist_two;
    int           mismatches;
    int           samples_seen;
    int           bytes_checked;
    int           escapes;
    int           closed_series;

    function new();
      steps         = TimeStepsReset;
      position      = '0;
      leading       = 1'b1;
      first_val     = '0;
      hist_one      = '0;
      hist_two      = '0;
      mismatches    = 0;
      samples_seen  = 0;
      bytes_checked = 0;
      escapes       = 0;
      closed_series = 0;
    endfunction

    function void set_steps(logic [14:0] value);
      steps = value;
    endfunction

    function int pending();
      return owed_bytes.size();
    endfunction

    // Work out the bytes one accepted sample produces.
    function void take_sample(logic [15:0] smp, logic fresh);
      logic [7:0]  burst[$];
      logic [14:0] len;
      logic [14:0] end_pos;
      logic        at_end;
      logic        coded;
      logic [15:0] guess;
      logic [15:0] resid;
      stream_byte_t item;
      len     = (steps < TimeStepsMin) ? TimeStepsMin : steps;
      end_pos = len - 15'd1;
      samples_seen++;
      if (fresh) begin
        burst.push_back(MarkNew);
        position = '0;
        leading  = 1'b1;
      end
      if (position == '0) begin
        burst.push_back(smp[7:0]);
        burst.push_back(smp[15:8]);
        first_val = smp;
        hist_one  = smp;
        hist_two  = smp;
        leading   = 1'b1;
        position  = 15'd1;
      end else begin
        at_end = (position >= end_pos);
        coded  = 1'b1;
        // The leading run ends at the first differing sample or at the end.
        if (leading) begin
          if (smp != first_val || at_end) begin
            burst.push_back(position[7:0]);
            burst.push_back({1'b0, position[14:8]});
            leading = 1'b0;
          end else begin
            coded = 1'b0;
          end
        end
        if (coded) begin
          guess = (hist_one << 1) - hist_two;
          resid = smp - guess;
          if ($signed(resid) > -NearLimit && $signed(resid) < NearLimit) begin
            burst.push_back(resid[7:0]);
          end else begin
            burst.push_back(MarkEscape);
            burst.push_back(resid[7:0]);
            burst.push_back(resid[15:8]);
            escapes++;
          end
          hist_two = hist_one;
          hist_one = smp;
        end
        if (at_end) begin
          burst.push_back(MarkNew);
          position = '0;
          leading  = 1'b1;
          closed_series++;
        end else begin
          position = position + 15'd1;
        end
      end
      foreach (burst[i]) begin
        item.data = burst[i];
        item.last = (i == burst.size() - 1);
        owed_bytes.push_back(item);
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 20) $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // Compare one output transfer with the oldest owed byte.
    task match_byte(logic [7:0] data, logic last);
      stream_byte_t want;
      bytes_checked++;
      if (owed_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h last %b", data, last));
      end else begin
        want = owed_bytes.pop_front();
        if (data !== want.data)
          report($sformatf("byte %02h, expected %02h", data, want.data));
        if (last !== want.last)
          report($sformatf("last %b on byte %02h, expected %b", last, data, want.last));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [14:0] cfg_wdata;
  logic        calm;
  int          settings_used;

  pde_in_if  in_ch ();
  pde_out_if out_ch ();

  delta_stream_board board = new();

  predictive_delta_series_encoder_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output back-pressure, switched off during the calm stretch.
  always @(posedge clk) begin
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 12);
  end

  // Transfer monitor feeding the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) board.take_sample(in_ch.sample, in_ch.new_file);
      if (out_ch.valid && out_ch.ready) board.match_byte(out_ch.out_byte, out_ch.last);
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin
    int stall;
    stall = 0;
    while (stall < StallLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall = 0;
      else stall++;
    end
    $display("timeout after %0d cycles without a transfer", StallLimit);
    $display("simulation failed");
    $finish;
  end

  // Offer one sample, with random gaps, and wait for its transfer.
  task automatic send_sample(input logic [15:0] smp, input logic fresh);
    while (!calm && $urandom_range(0, 99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.sample   <= smp;
    in_ch.new_file <= fresh;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Hold the input until every owed byte has come out.
  task automatic drain_stream();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Write the series length once the block is idle.
  task automatic write_steps(input logic [14:0] value);
    drain_stream();
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    board.set_steps(value);
    settings_used++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random series: mostly smooth content with a short leading run, plus
  // cut-off series, large jumps and raw noise.
  task automatic run_phase(input logic [14:0] steps, input int count);
    int          left;
    int          len;
    int          span;
    int          run_len;
    logic        need_file;
    logic        fresh;
    logic [15:0] smp;
    logic [15:0] hist_a;
    logic [15:0] hist_b;
    logic [15:0] start;
    left      = count;
    need_file = 1'b1;
    write_steps(steps);
    while (left > 0) begin
      len  = (steps < TimeStepsMin) ? TimeStepsMin : steps;
      span = (len > 30) ? $urandom_range(3, 12) : len;
      if ($urandom_range(0, 99) < 10) span = $urandom_range(1, span);
      start   = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 400) - 200);
      run_len = ($urandom_range(0, 99) < 20) ? $urandom_range(0, span - 1)
                                             : $urandom_range(0, 2);
      fresh   = need_file || ($urandom_range(0, 99) < 15);
      hist_a  = start;
      hist_b  = start;
      for (int k = 0; k < span && left > 0; k++) begin
        if (k == 0 || k <= run_len) smp = start;
        else if ($urandom_range(0, 99) < 5) smp = 16'($urandom);
        else if ($urandom_range(0, 99) < 15)
          smp = (hist_a << 1) - hist_b + 16'($urandom_range(0, 1000) - 500);
        else
          smp = (hist_a << 1) - hist_b + 16'($urandom_range(0, 260) - 130);
        send_sample(smp, (k == 0) && fresh);
        hist_b = hist_a;
        hist_a = smp;
        left--;
      end
      need_file = (span < len);
    end
  endtask

  // Main sequence.
  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    calm           <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.sample   <= '0;
    in_ch.new_file <= 1'b0;
    settings_used  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Residual limits on both sides, leading run and series close.
    write_steps(15'd8);
    send_sample(16'd100, 1'b1);
    send_sample(16'd100, 1'b0);
    send_sample(16'd100, 1'b0);
    send_sample(16'd226, 1'b0);
    send_sample(16'd226, 1'b0);
    send_sample(16'd353, 1'b0);
    send_sample(16'd353, 1'b0);
    send_sample(16'd225, 1'b0);
    // Sample extremes with a wrapping prediction.
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    // New file in the middle of a series.
    send_sample(16'd5, 1'b1);
    send_sample(16'd7, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    // Shorter length while the series is past its new end.
    write_steps(15'd3);
    send_sample(16'hFFFF, 1'b0);
    // Length below the minimum, arrival with an escaped residual.
    write_steps(15'd0);
    send_sample(16'd0, 1'b1);
    send_sample(16'd0, 1'b0);
    send_sample(16'd1000, 1'b0);
    // Longest series setting.
    write_steps(15'h7FFF);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);

    // Random phases over several lengths; one runs without any idling.
    run_phase(15'd3, 40);
    run_phase(15'd16, 35);
    run_phase(15'd1, 25);
    calm <= 1'b1;
    run_phase(15'd7, 45);
    calm <= 1'b0;
    run_phase(15'h7FFF, 30);
    run_phase(15'd5, 25);

    drain_stream();
    repeat (SettleCycles) @(posedge clk);
    $display("covered %0d samples over %0d length settings, %0d series closed",
             board.samples_seen, settings_used, board.closed_series);
    $display("checked %0d stream bytes, %0d escaped residuals, %0d mismatches",
             board.bytes_checked, board.escapes, board.mismatches);
    if (board.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
